FILE: rtl/core/assert_macros.svh
// Assertion macros used by the RTL top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error("%m");
`define ASSERT_NEXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error("%m");
`endif

FILE: rtl/core/e2q_pkg.sv
// Package: constants, types and tables for the Euler to quaternion converter
`timescale 1ns / 1ps
`default_nettype none
package e2q_pkg;
    localparam int CordicIterations = 16;
    localparam int AtanEntries = 24;
    localparam int NumIter = (CordicIterations < AtanEntries) ? CordicIterations : AtanEntries;
    localparam int CntW = $clog2(NumIter + 1);
    localparam logic [31:0] PhaseMult = 32'd3054198966;
    localparam logic signed [33:0] GainQ30 = 34'sh026DD3B6A;
    localparam int QW = 34;
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    typedef logic signed [QW-1:0] trig_t;

    typedef struct packed {
        trig_t x;
        trig_t y;
        logic signed [31:0] z;
        logic [1:0] quad;
    } cord_t;

    function automatic logic signed [31:0] atan_turns(input int i);
        logic [31:0] t [0:23];
        t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
              32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
              32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
              32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
              32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
              32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
        return $signed(t[i]);
    endfunction
endpackage
`default_nettype wire

FILE: rtl/core/e2q_cell.sv
// One CORDIC micro-rotation cell for three angles
`timescale 1ns / 1ps
`default_nettype none
module e2q_cell (
    input  wire logic                        clk,
    input  wire logic [e2q_pkg::CntW-1:0]    stage,
    input  wire e2q_pkg::cord_t              din [3],
    output e2q_pkg::cord_t                   dout [3]
);
    e2q_pkg::cord_t dout_next [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dout_next[k] = din[k];
            if (!din[k].z[31])
            begin
                dout_next[k].x = din[k].x - (din[k].y >>> stage);
                dout_next[k].y = din[k].y + (din[k].x >>> stage);
                dout_next[k].z = din[k].z - e2q_pkg::atan_turns(int'(stage));
            end
            else
            begin
                dout_next[k].x = din[k].x + (din[k].y >>> stage);
                dout_next[k].y = din[k].y - (din[k].x >>> stage);
                dout_next[k].z = din[k].z + e2q_pkg::atan_turns(int'(stage));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dout <= dout_next;
    end
endmodule
`default_nettype wire

FILE: rtl/core/e2q_comb.sv
// Quaternion product stages: quadrant correction, three-way products, sums, rounding, saturation
`timescale 1ns / 1ps
`default_nettype none
module e2q_comb (
    input  wire logic                clk,
    input  wire e2q_pkg::cord_t      din [3],
    output logic signed [15:0]       quat_w,
    output logic signed [15:0]       quat_x,
    output logic signed [15:0]       quat_y,
    output logic signed [15:0]       quat_z
);
    e2q_pkg::trig_t c_reg [3];
    e2q_pkg::trig_t s_reg [3];
    e2q_pkg::trig_t p2_reg [4];
    e2q_pkg::trig_t p2_next [4];
    e2q_pkg::trig_t cp_reg, sp_reg;
    e2q_pkg::trig_t p3_reg [8];
    e2q_pkg::trig_t p3_next [8];
    logic signed [15:0] q_next [4];

    function automatic e2q_pkg::trig_t mul30(input e2q_pkg::trig_t a, input e2q_pkg::trig_t b);
        logic signed [67:0] p;
        p = a * b + 68'sd536870912;
        return p[63:30];
    endfunction

    function automatic logic signed [15:0] to_q14(input logic signed [34:0] v);
        logic signed [34:0] r;
        r = (v + 35'sd32768) >>> 16;
        if (r > 35'sd16384)
            return 16'sd16384;
        else if (r < -35'sd16384)
            return -16'sd16384;
        else
            return r[15:0];
    endfunction

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            case (din[k].quad)
                e2q_pkg::QUAD_0:
                begin
                    c_reg[k] <= din[k].x;
                    s_reg[k] <= din[k].y;
                end
                e2q_pkg::QUAD_1:
                begin
                    c_reg[k] <= -din[k].y;
                    s_reg[k] <= din[k].x;
                end
                e2q_pkg::QUAD_2:
                begin
                    c_reg[k] <= -din[k].x;
                    s_reg[k] <= -din[k].y;
                end
                default:
                begin
                    c_reg[k] <= din[k].y;
                    s_reg[k] <= -din[k].x;
                end
            endcase
        end
    end

    // index 0 yaw, 1 pitch, 2 roll
    always_comb
    begin
        p2_next[0] = mul30(c_reg[0], c_reg[2]);
        p2_next[1] = mul30(s_reg[0], s_reg[2]);
        p2_next[2] = mul30(c_reg[0], s_reg[2]);
        p2_next[3] = mul30(s_reg[0], c_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        p2_reg <= p2_next;
        cp_reg <= c_reg[1];
        sp_reg <= s_reg[1];
    end

    always_comb
    begin
        p3_next[0] = mul30(p2_reg[0], cp_reg);
        p3_next[1] = mul30(p2_reg[1], sp_reg);
        p3_next[2] = mul30(p2_reg[2], cp_reg);
        p3_next[3] = mul30(p2_reg[3], sp_reg);
        p3_next[4] = mul30(p2_reg[0], sp_reg);
        p3_next[5] = mul30(p2_reg[1], cp_reg);
        p3_next[6] = mul30(p2_reg[3], cp_reg);
        p3_next[7] = mul30(p2_reg[2], sp_reg);
    end

    always_ff @(posedge clk)
    begin
        p3_reg <= p3_next;
    end

    always_comb
    begin
        q_next[0] = to_q14(35'(p3_reg[0]) + 35'(p3_reg[1]));
        q_next[1] = to_q14(35'(p3_reg[2]) - 35'(p3_reg[3]));
        q_next[2] = to_q14(35'(p3_reg[4]) + 35'(p3_reg[5]));
        q_next[3] = to_q14(35'(p3_reg[6]) - 35'(p3_reg[7]));
    end

    always_ff @(posedge clk)
    begin
        quat_w <= q_next[0];
        quat_x <= q_next[1];
        quat_y <= q_next[2];
        quat_z <= q_next[3];
    end
endmodule
`default_nettype wire

FILE: rtl/core/euler_to_quaternion_top.sv
// Top level: Euler angles (ZYX) to unit quaternion converter
// From start to done an item passes the phase register, one register per CORDIC cell and the product registers.
// Throughput: one item per cycle; busy stays low, the CORDIC cell row is fully pipelined.
// The result shows for one cycle with done high; the receiver cannot stall.
// Reset clears the valid line only; the data path carries no reset.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module euler_to_quaternion_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [16:0] yaw_deg,
    input  wire logic signed [16:0] pitch_deg,
    input  wire logic signed [16:0] roll_deg,
    output logic                    done,
    output logic signed [15:0]      quat_w,
    output logic signed [15:0]      quat_x,
    output logic signed [15:0]      quat_y,
    output logic signed [15:0]      quat_z
);
    localparam int Lat = e2q_pkg::NumIter + 5;
    localparam int StageW = e2q_pkg::CntW;

    e2q_pkg::cord_t stage_reg [e2q_pkg::NumIter+1][3];
    e2q_pkg::cord_t phase_next [3];
    logic [Lat-1:0] vld_reg;
    logic signed [16:0] ang [3];

    assign busy = 1'b0;
    assign ang[0] = yaw_deg;
    assign ang[1] = pitch_deg;
    assign ang[2] = roll_deg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            logic signed [49:0] prod;
            logic [49:0] pu;
            logic [31:0] ph;
            prod = ang[k] * $signed({1'b0, e2q_pkg::PhaseMult});
            pu = $unsigned(prod) + 50'h8000;
            ph = pu[47:16];
            phase_next[k].quad = ph[31:30];
            phase_next[k].z = {2'b00, ph[29:0]};
            phase_next[k].x = e2q_pkg::GainQ30;
            phase_next[k].y = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg[0] <= phase_next;
    end

    for (genvar i = 0; i < e2q_pkg::NumIter; i++)
    begin : g_cell
        e2q_cell u_cell (
            .clk   (clk),
            .stage (StageW'(i)),
            .din   (stage_reg[i]),
            .dout  (stage_reg[i+1])
        );
    end

    e2q_comb u_comb (
        .clk    (clk),
        .din    (stage_reg[e2q_pkg::NumIter]),
        .quat_w (quat_w),
        .quat_x (quat_x),
        .quat_y (quat_y),
        .quat_z (quat_z)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[Lat-2:0], start & ~busy};
    end

    assign done = vld_reg[Lat-1];

    `ASSERT_NEXT(a_vld_shift, clk, rst_n, start, vld_reg[0])
    `ASSERT_NEXT(a_vld_idle, clk, rst_n, !start, !vld_reg[0])
    `ASSERT_IMPL(a_never_busy, clk, rst_n, 1'b1, !busy)
endmodule
`default_nettype wire
